/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the telemetry converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ETC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ETC_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ETC_ASSERT(lbl, clk, rst, prop)
`define ETC_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

/* src/etc_pkg.sv */
// ----------------------------------------------------------------------------
// ESC telemetry converter package
// Field widths, scaling constants and the NTC resistance table.
// ----------------------------------------------------------------------------
package etc_pkg;

  localparam int WORD_W  = 16;
  localparam int IDENT_W = 8;
  localparam int POLE_W  = 8;
  localparam int SPEED_W = 15;
  localparam int MV_W    = 14;
  localparam int CA_W    = 16;
  localparam int TEMP_W  = 7;
  localparam int NTC_W   = 12;

  localparam int TABLE_ENTRIES = 100;
  localparam logic [TEMP_W-1:0] TABLE_LAST = TEMP_W'(TABLE_ENTRIES - 1);

  localparam logic [POLE_W-1:0]  POLE_RESET = 8'd6;
  localparam logic [IDENT_W-1:0] ALIVE_CODE = 8'hAB;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 15'h7FFF;

  localparam logic [WORD_W-1:0] RPM_SCALE  = 16'd60000;
  localparam logic [WORD_W-1:0] VOLT_SCALE = 16'd15650;
  localparam logic [WORD_W-1:0] CURR_SCALE = 16'd50000;
  localparam logic [WORD_W-1:0] KOHM_SCALE = 16'd1000;

  // NTC resistance per degree in hundredths of a kilo-ohm.
  localparam logic [NTC_W-1:0] NTC_TABLE [TABLE_ENTRIES] = '{
    12'd2780, 12'd2660, 12'd2546, 12'd2438, 12'd2335, 12'd2237, 12'd2144, 12'd2055,
    12'd1970, 12'd1890, 12'd1813, 12'd1739, 12'd1669, 12'd1602, 12'd1539, 12'd1478,
    12'd1420, 12'd1364, 12'd1311, 12'd1261, 12'd1212, 12'd1166, 12'd1122, 12'd1079,
    12'd1039, 12'd1000, 12'd963,  12'd927,  12'd893,  12'd861,  12'd830,  12'd800,
    12'd771,  12'd743,  12'd716,  12'd692,  12'd667,  12'd644,  12'd622,  12'd600,
    12'd580,  12'd560,  12'd541,  12'd523,  12'd505,  12'd488,  12'd472,  12'd457,
    12'd442,  12'd427,  12'd413,  12'd400,  12'd387,  12'd375,  12'd363,  12'd351,
    12'd340,  12'd330,  12'd319,  12'd309,  12'd300,  12'd291,  12'd282,  12'd273,
    12'd265,  12'd257,  12'd249,  12'd242,  12'd235,  12'd228,  12'd221,  12'd215,
    12'd209,  12'd203,  12'd197,  12'd191,  12'd186,  12'd180,  12'd175,  12'd170,
    12'd166,  12'd161,  12'd157,  12'd152,  12'd148,  12'd144,  12'd140,  12'd137,
    12'd133,  12'd129,  12'd126,  12'd123,  12'd119,  12'd116,  12'd113,  12'd110,
    12'd107,  12'd105,  12'd102,  12'd99
  };

  function automatic logic [NTC_W-1:0] ntc_entry(input logic [TEMP_W-1:0] idx);
    ntc_entry = NTC_TABLE[idx];
  endfunction

endpackage

/* src/etc_channels.sv */
// ----------------------------------------------------------------------------
// ESC telemetry converter channels
// Valid/ready interfaces for raw records, converted results and pole count.
// ----------------------------------------------------------------------------
interface etc_in_if import etc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  commutation_count;
  logic [WORD_W-1:0]  voltage_word;
  logic [WORD_W-1:0]  thermistor_word;
  logic [WORD_W-1:0]  current_word;
  logic [IDENT_W-1:0] ident_byte;
  logic [WORD_W-1:0]  now_ms;

  modport source (
    output valid, commutation_count, voltage_word, thermistor_word,
    output current_word, ident_byte, now_ms,
    input  ready
  );
  modport sink (
    input  valid, commutation_count, voltage_word, thermistor_word,
    input  current_word, ident_byte, now_ms,
    output ready
  );
endinterface

interface etc_out_if import etc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_rpm;
  logic [MV_W-1:0]    supply_mv;
  logic [CA_W-1:0]    current_ca;
  logic [TEMP_W-1:0]  temp_index;
  logic               alive_flag;

  modport source (
    output valid, speed_rpm, supply_mv, current_ca, temp_index, alive_flag,
    input  ready
  );
  modport sink (
    input  valid, speed_rpm, supply_mv, current_ca, temp_index, alive_flag,
    output ready
  );
endinterface

interface etc_cfg_if import etc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [POLE_W-1:0] pole_count;

  modport source (output valid, pole_count, input ready);
  modport sink (input valid, pole_count, output ready);
endinterface

/* src/esc_telemetry_converter_unit.sv */
// ----------------------------------------------------------------------------
// ESC telemetry converter
// Converts raw speed controller telemetry records into engineering units.
// ----------------------------------------------------------------------------
// Usage:
//   telemetry_in carries one raw record per item. The unit takes a record only
//   while it is idle, then works on it with one shared multiplier and one
//   shared subtract/compare unit under a small sequencer: five products, a
//   saturation check, a 15-step restoring division for the speed, and a scan
//   of the NTC table that checks one entry per cycle.
//   The table scan takes up most of the time from acceptance to result valid;
//   the 15 division steps are skipped when the speed saturates. The unit takes
//   no new record until it has finished the last one and is idle again.
//   telemetry_out holds the result in an output register; if the receiver
//   stalls, the unit still accepts and processes the next record and waits
//   at its final step until the register is free.
//   pole_cfg writes the pole count at any time; it is meant to be written
//   while no record is in flight.
//   Reset sets the pole count to 6, the previous timestamp to 0, and empties
//   the output register.
// ----------------------------------------------------------------------------
module esc_telemetry_converter_unit
  import etc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  etc_in_if.sink    telemetry_in,
  etc_out_if.source telemetry_out,
  etc_cfg_if.sink   pole_cfg
);

  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NUM   = 4'd1;
  localparam logic [3:0] S_DEN   = 4'd2;
  localparam logic [3:0] S_VOLT  = 4'd3;
  localparam logic [3:0] S_CURR  = 4'd4;
  localparam logic [3:0] S_LHS   = 4'd5;
  localparam logic [3:0] S_SAT   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_TSCAN = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int MUL_A_W = WORD_W + 1;
  localparam int MUL_P_W = MUL_A_W + WORD_W;
  localparam int CMP_W   = 40;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = WORD_W + POLE_W;
  localparam int LHS_W   = 27;
  localparam int PRD_W   = NTC_W + WORD_W;
  localparam int DSH_W   = DEN_W + SPEED_W - 1;

  logic [3:0]         state;
  logic [POLE_W-1:0]  pole_count;
  logic [WORD_W-1:0]  last_time;

  logic [WORD_W-1:0]  count;
  logic [WORD_W-1:0]  vraw;
  logic [WORD_W-1:0]  traw;
  logic [WORD_W-1:0]  iraw;
  logic               alive;
  logic [WORD_W-1:0]  elapsed;

  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [MV_W-1:0]    supply_res;
  logic [CA_W-1:0]    current_res;
  logic [LHS_W-1:0]   lhs;
  logic [NUM_W-1:0]   rem;
  logic [DSH_W-1:0]   dsh;
  logic [3:0]         bit_cnt;
  logic [SPEED_W-1:0] quot;

  logic [TEMP_W-1:0]  idx;
  logic [TEMP_W-1:0]  pidx;
  logic               pvalid;
  logic [PRD_W-1:0]   prod;
  logic [TEMP_W-1:0]  temp_res;

  logic               out_valid;
  logic [SPEED_W-1:0] out_speed;
  logic [MV_W-1:0]    out_supply;
  logic [CA_W-1:0]    out_current;
  logic [TEMP_W-1:0]  out_temp;
  logic               out_alive;

  logic [MUL_A_W-1:0] mul_a;
  logic [WORD_W-1:0]  mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [CMP_W-1:0]   cmp_a;
  logic [CMP_W-1:0]   cmp_b;
  logic [CMP_W:0]     cmp_diff;
  logic               cmp_ge;
  logic               in_fire;
  logic               out_fire;
  logic               out_free;

  assign in_fire  = telemetry_in.valid && telemetry_in.ready;
  assign out_fire = telemetry_out.valid && telemetry_out.ready;
  assign out_free = !out_valid || telemetry_out.ready;

  assign telemetry_in.ready = (state == S_IDLE);
  assign pole_cfg.ready     = 1'b1;

  assign telemetry_out.valid      = out_valid;
  assign telemetry_out.speed_rpm  = out_speed;
  assign telemetry_out.supply_mv  = out_supply;
  assign telemetry_out.current_ca = out_current;
  assign telemetry_out.temp_index = out_temp;
  assign telemetry_out.alive_flag = out_alive;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_NUM: begin
        mul_a = {1'b0, count};
        mul_b = RPM_SCALE;
      end
      S_DEN: begin
        mul_a = MUL_A_W'(pole_count);
        mul_b = elapsed;
      end
      S_VOLT: begin
        mul_a = {1'b0, vraw};
        mul_b = VOLT_SCALE;
      end
      S_CURR: begin
        mul_a = {1'b0, iraw};
        mul_b = CURR_SCALE;
      end
      S_LHS: begin
        mul_a = (MUL_A_W'(1) << WORD_W) - {1'b0, traw};
        mul_b = KOHM_SCALE;
      end
      S_TSCAN: begin
        mul_a = MUL_A_W'(ntc_entry(idx));
        mul_b = traw;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared subtract/compare unit.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state)
      S_SAT: begin
        cmp_a = CMP_W'(num);
        cmp_b = CMP_W'({den, {SPEED_W{1'b0}}});
      end
      S_DIV: begin
        cmp_a = CMP_W'(rem);
        cmp_b = CMP_W'(dsh);
      end
      S_TSCAN: begin
        // prod >= lhs means this entry does not qualify.
        cmp_a = CMP_W'(prod);
        cmp_b = CMP_W'(lhs);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign cmp_ge   = !cmp_diff[CMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_count <= POLE_RESET;
    end else if (pole_cfg.valid && pole_cfg.ready) begin
      pole_count <= pole_cfg.pole_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_time <= '0;
      pvalid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            last_time <= telemetry_in.now_ms;
            state     <= S_NUM;
          end
        end
        S_NUM:  state <= S_DEN;
        S_DEN:  state <= S_VOLT;
        S_VOLT: state <= S_CURR;
        S_CURR: state <= S_LHS;
        S_LHS:  state <= S_SAT;
        S_SAT: begin
          // Also covers a zero divisor, since anything is at least zero.
          state  <= cmp_ge ? S_TSCAN : S_DIV;
          pvalid <= 1'b0;
        end
        S_DIV: begin
          if (bit_cnt == '0) begin
            state  <= S_TSCAN;
            pvalid <= 1'b0;
          end
        end
        S_TSCAN: begin
          if (pvalid && (!cmp_ge || pidx == TABLE_LAST)) begin
            state <= S_DONE;
          end else begin
            pvalid <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          count   <= telemetry_in.commutation_count;
          vraw    <= telemetry_in.voltage_word;
          traw    <= telemetry_in.thermistor_word;
          iraw    <= telemetry_in.current_word;
          alive   <= (telemetry_in.ident_byte == ALIVE_CODE);
          elapsed <= telemetry_in.now_ms - last_time;
        end
      end
      S_NUM:  num         <= mul_p[NUM_W-1:0];
      S_DEN:  den         <= mul_p[DEN_W-1:0];
      S_VOLT: supply_res  <= mul_p[WORD_W+MV_W-1:WORD_W];
      S_CURR: current_res <= mul_p[WORD_W+CA_W-1:WORD_W];
      S_LHS:  lhs         <= mul_p[LHS_W-1:0];
      S_SAT: begin
        rem     <= num;
        dsh     <= {den, {(SPEED_W-1){1'b0}}};
        bit_cnt <= 4'(SPEED_W - 1);
        quot    <= cmp_ge ? SPEED_MAX : '0;
        idx     <= '0;
      end
      S_DIV: begin
        if (cmp_ge) begin
          rem <= cmp_diff[NUM_W-1:0];
        end
        quot    <= {quot[SPEED_W-2:0], cmp_ge};
        dsh     <= dsh >> 1;
        bit_cnt <= bit_cnt - 4'd1;
      end
      S_TSCAN: begin
        if (pvalid && !cmp_ge) begin
          temp_res <= pidx;
        end else if (pvalid && pidx == TABLE_LAST) begin
          temp_res <= '0;
        end else begin
          prod <= mul_p[PRD_W-1:0];
          pidx <= idx;
          if (idx != TABLE_LAST) begin
            idx <= idx + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_speed   <= quot;
      out_supply  <= supply_res;
      out_current <= current_res;
      out_temp    <= temp_res;
      out_alive   <= alive;
    end
  end

  `ETC_ASSERT(a_sat_skips_div, clk, rst,
    (state == S_SAT && cmp_ge) |=> (state == S_TSCAN && quot == SPEED_MAX))
  `ETC_ASSERT(a_accept_starts, clk, rst,
    in_fire |=> (state == S_NUM && elapsed == $past(telemetry_in.now_ms - last_time)))
  `ETC_ASSERT(a_result_from_done, clk, rst,
    $rose(out_valid) |-> $past(state == S_DONE))
  `ETC_ASSERT_NEVER(a_scan_in_range, clk, rst,
    (state == S_TSCAN && (idx > TABLE_LAST || (pvalid && pidx > TABLE_LAST))))
  `ETC_ASSERT_NEVER(a_temp_in_range, clk, rst,
    (state == S_DONE && temp_res > TABLE_LAST))

endmodule
